>>> rtl/core/fixed_point_alu_macros.svh
// Assertion macros used by fixed_point_alu.sv, the RTL of the fixed-point ALU.
// Define NO_ASSERTIONS to compile them away.
`ifndef FIXED_POINT_ALU_MACROS_SVH
`define FIXED_POINT_ALU_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked property checked outside reset.
`define FPA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fixed_point_alu: assertion failed");
// Clocked property checked during reset as well.
`define FPA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("fixed_point_alu: assertion failed");
`else
`define FPA_ASSERT(label, clk, rst, prop)
`define FPA_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> rtl/core/fpa_pkg.sv
`default_nettype none
package fpa_pkg;

  localparam int unsigned DATA_W            = 32;
  localparam int unsigned OP_W              = 4;
  localparam int unsigned PROD_W            = 2 * DATA_W;
  localparam int unsigned FRACTION_BITS_DEF = 8;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MIN = 4'd4,
    OP_MAX = 4'd5,
    OP_INC = 4'd6,
    OP_DEC = 4'd7,
    OP_CMP = 4'd8
  } op_t;

  // Everything an item carries alongside the divider's remainder and quotient.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] res;
    logic [PROD_W-1:0] prod;
    logic [DATA_W-1:0] den;
    logic              neg;
    logic              lt;
    logic              eq;
    logic              gt;
    logic              dz;
    logic              ov;
  } side_t;

  typedef struct packed {
    logic              ov;
    logic [DATA_W-1:0] val;
  } sat_t;

  // Saturate a sign and magnitude to the signed 32-bit range.
  function automatic sat_t sat_mag(input logic neg, input logic [PROD_W-1:0] mag);
    sat_t              r;
    logic [PROD_W-1:0] n;
    n = PROD_W'(0) - mag;
    if (neg) begin
      r.ov  = mag > PROD_W'(64'h8000_0000);
      r.val = r.ov ? 32'h8000_0000 : n[DATA_W-1:0];
    end else begin
      r.ov  = mag > PROD_W'(64'h7FFF_FFFF);
      r.val = r.ov ? 32'h7FFF_FFFF : mag[DATA_W-1:0];
    end
    return r;
  endfunction

  // Saturate a 33-bit two's complement sum.
  function automatic sat_t sat_sum(input logic [DATA_W:0] s);
    sat_t r;
    r.ov = s[DATA_W] != s[DATA_W-1];
    if (r.ov) begin
      r.val = s[DATA_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r.val = s[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/fpa_ifs.sv
`default_nettype none
interface fpa_req_if;
  logic                         valid;
  logic                         ready;
  logic [fpa_pkg::OP_W-1:0]     req_type;
  logic signed [fpa_pkg::DATA_W-1:0] operand_a;
  logic signed [fpa_pkg::DATA_W-1:0] operand_b;

  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [fpa_pkg::DATA_W-1:0] result_value;
  logic                              a_less;
  logic                              a_equal;
  logic                              a_greater;
  logic                              div_zero;
  logic                              overflowed;

  modport source (output valid, result_value, a_less, a_equal, a_greater, div_zero,
                  overflowed, input ready);
  modport sink   (input valid, result_value, a_less, a_equal, a_greater, div_zero,
                  overflowed, output ready);
endinterface
`default_nettype wire

>>> rtl/core/fixed_point_alu.sv
// Stages: input, operand, divider (one quotient bit per stage), then output.
// Throughput: one item per cycle unless a held response beat stalls the pipeline.
// A response beat held by the sink stalls the whole pipeline in place.
// Reset clears every valid bit; the data registers are not reset.
`default_nettype none
`include "fixed_point_alu_macros.svh"
module fixed_point_alu #(
  parameter int unsigned FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  fpa_req_if.sink  req,
  fpa_rsp_if.source rsp
);

  localparam int unsigned DW = fpa_pkg::DATA_W;
  localparam int unsigned PW = fpa_pkg::PROD_W;
  localparam int unsigned NW = DW + FRACTION_BITS;

  logic adv;

  // Input stage.
  logic                   s0_valid;
  logic [fpa_pkg::OP_W-1:0] s0_op;
  logic [DW-1:0]          s0_a;
  logic [DW-1:0]          s0_b;

  // Divider chain; index 0 is the operand stage.
  logic                   div_valid [0:NW];
  fpa_pkg::side_t         div_side  [0:NW];
  logic [DW-1:0]          div_rem   [0:NW];
  logic [NW-1:0]          div_acc   [0:NW];

  logic                   out_valid;
  logic [DW-1:0]          out_res;
  logic                   out_lt;
  logic                   out_eq;
  logic                   out_gt;
  logic                   out_dz;
  logic                   out_ov;

  assign adv       = !out_valid || rsp.ready;
  assign req.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_op <= req.req_type;
      s0_a  <= req.operand_a;
      s0_b  <= req.operand_b;
    end
  end

  // Operand stage: flags, simple results, magnitudes and the product.
  logic [DW-1:0]      mag_a;
  logic [DW-1:0]      mag_b;
  logic               lt;
  logic               eq;
  fpa_pkg::sat_t      sat;
  fpa_pkg::side_t     side0;

  always_comb begin
    mag_a = s0_a[DW-1] ? DW'(0) - s0_a : s0_a;
    mag_b = s0_b[DW-1] ? DW'(0) - s0_b : s0_b;
    lt    = $signed(s0_a) < $signed(s0_b);
    eq    = s0_a == s0_b;
    sat   = '0;
    case (s0_op)
      fpa_pkg::OP_ADD: sat = fpa_pkg::sat_sum({s0_a[DW-1], s0_a} + {s0_b[DW-1], s0_b});
      fpa_pkg::OP_SUB: sat = fpa_pkg::sat_sum({s0_a[DW-1], s0_a} - {s0_b[DW-1], s0_b});
      fpa_pkg::OP_INC: sat = fpa_pkg::sat_sum({s0_a[DW-1], s0_a} + (DW+1)'(1));
      fpa_pkg::OP_DEC: sat = fpa_pkg::sat_sum({s0_a[DW-1], s0_a} - (DW+1)'(1));
      fpa_pkg::OP_MIN: sat.val = lt ? s0_a : s0_b;
      fpa_pkg::OP_MAX: sat.val = (!lt && !eq) ? s0_a : s0_b;
      default:         sat = '0;
    endcase
    side0.op   = s0_op;
    side0.res  = sat.val;
    side0.ov   = sat.ov;
    side0.prod = PW'(mag_a) * PW'(mag_b);
    side0.den  = mag_b;
    side0.neg  = s0_a[DW-1] != s0_b[DW-1];
    side0.lt   = lt;
    side0.eq   = eq;
    side0.gt   = !lt && !eq;
    side0.dz   = (s0_op == fpa_pkg::OP_DIV) && (s0_b == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_valid[0] <= 1'b0;
    end else if (adv) begin
      div_valid[0] <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_side[0] <= side0;
      div_rem[0]  <= '0;
      div_acc[0]  <= NW'(mag_a) << FRACTION_BITS;
    end
  end

  for (genvar i = 0; i < NW; i++) begin : g_div
    fpa_div_stage #(.NW(NW)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (div_valid[i]),
      .in_side   (div_side[i]),
      .in_rem    (div_rem[i]),
      .in_acc    (div_acc[i]),
      .out_valid (div_valid[i+1]),
      .out_side  (div_side[i+1]),
      .out_rem   (div_rem[i+1]),
      .out_acc   (div_acc[i+1])
    );
  end

  // Final stage: rounding and saturation of the product and the quotient.
  fpa_pkg::side_t sf;
  logic           round_up;
  logic [PW-1:0]  quot;
  logic [PW-1:0]  mul_mag;
  fpa_pkg::sat_t  fin;

  always_comb begin
    sf       = div_side[NW];
    round_up = {div_rem[NW], 1'b0} >= {1'b0, sf.den};
    quot     = PW'(div_acc[NW]) + PW'(round_up);
    mul_mag  = (sf.prod + ((PW'(1) << FRACTION_BITS) >> 1)) >> FRACTION_BITS;
    fin.val  = sf.res;
    fin.ov   = sf.ov;
    if (sf.op == fpa_pkg::OP_MUL) begin
      fin = fpa_pkg::sat_mag(sf.neg, mul_mag);
    end else if (sf.op == fpa_pkg::OP_DIV && !sf.dz) begin
      fin = fpa_pkg::sat_mag(sf.neg, quot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= div_valid[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= fin.val;
      out_lt  <= sf.lt;
      out_eq  <= sf.eq;
      out_gt  <= sf.gt;
      out_dz  <= sf.dz;
      out_ov  <= fin.ov;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_res;
  assign rsp.a_less       = out_lt;
  assign rsp.a_equal      = out_eq;
  assign rsp.a_greater    = out_gt;
  assign rsp.div_zero     = out_dz;
  assign rsp.overflowed   = out_ov;

  `FPA_ASSERT(a_flags_onehot, clk, rst, out_valid |-> $onehot({out_lt, out_eq, out_gt}))
  `FPA_ASSERT(a_dz_clean, clk, rst, out_valid && out_dz |-> out_res == '0 && !out_ov)
  `FPA_ASSERT(a_ov_limit, clk, rst,
    out_valid && out_ov |-> out_res == 32'h7FFF_FFFF || out_res == 32'h8000_0000)
  `FPA_ASSERT_ALWAYS(a_stall_cause, clk, !req.ready |-> out_valid && !rsp.ready)

endmodule
`default_nettype wire

>>> rtl/core/fpa_div_stage.sv
`default_nettype none
// One bit of restoring division. The accumulator shifts numerator bits out at
// the top and quotient bits in at the bottom.
module fpa_div_stage #(
  parameter int unsigned NW = fpa_pkg::DATA_W + fpa_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire fpa_pkg::side_t            in_side,
  input  wire logic [fpa_pkg::DATA_W-1:0] in_rem,
  input  wire logic [NW-1:0]             in_acc,
  output logic                           out_valid,
  output fpa_pkg::side_t                 out_side,
  output logic [fpa_pkg::DATA_W-1:0]     out_rem,
  output logic [NW-1:0]                  out_acc
);

  logic [fpa_pkg::DATA_W:0]   trial;
  logic [fpa_pkg::DATA_W:0]   diff;
  logic                       ge;
  logic [fpa_pkg::DATA_W-1:0] rem_next;

  always_comb begin
    trial    = {in_rem, in_acc[NW-1]};
    ge       = trial >= {1'b0, in_side.den};
    diff     = trial - {1'b0, in_side.den};
    // For a nonzero divisor the remainder stays below it, so 32 bits hold it.
    rem_next = ge ? diff[fpa_pkg::DATA_W-1:0] : trial[fpa_pkg::DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      out_rem  <= rem_next;
      out_acc  <= {in_acc[NW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import fpa_pkg::*;

  localparam int unsigned FRAC       = FRACTION_BITS_DEF;
  localparam int unsigned LATENCY    = 34 + FRAC;
  localparam int unsigned N_RANDOM   = 1000;
  localparam int unsigned CYCLE_CAP  = 200000;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              lt;
    logic              eq;
    logic              gt;
    logic              dz;
    logic              ov;
  } alu_result_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    bit                typed;
    alu_result_t       res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fpa_req_if req ();
  fpa_rsp_if rsp ();

  fixed_point_alu #(.FRACTION_BITS(FRAC)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  alu_result_t pending_results[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  function automatic logic [PROD_W-1:0] abs64(input logic signed [PROD_W-1:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [DATA_W-1:0] clamp(input logic neg,
                                              input logic [PROD_W-1:0] mag,
                                              inout logic ov);
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        ov = 1'b1;
        return 32'h8000_0000;
      end
      return DATA_W'(PROD_W'(0) - mag);
    end
    if (mag > 64'h7FFF_FFFF) begin
      ov = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return mag[DATA_W-1:0];
  endfunction

  function automatic alu_result_t compute_alu(input logic [OP_W-1:0] op,
                                              input logic [DATA_W-1:0] a_raw,
                                              input logic [DATA_W-1:0] b_raw);
    alu_result_t                r;
    logic signed [PROD_W-1:0]   a;
    logic signed [PROD_W-1:0]   b;
    logic signed [PROD_W-1:0]   s;
    logic [PROD_W-1:0]          mag;
    logic [PROD_W-1:0]          num;
    logic [PROD_W-1:0]          den;
    logic                       ov;
    a  = PROD_W'($signed(a_raw));
    b  = PROD_W'($signed(b_raw));
    ov = 1'b0;
    r  = '0;
    case (op)
      OP_ADD: begin
        s = a + b;
        r.value = clamp(s < 0, abs64(s), ov);
      end
      OP_SUB: begin
        s = a - b;
        r.value = clamp(s < 0, abs64(s), ov);
      end
      OP_MUL: begin
        mag = abs64(a) * abs64(b);
        mag = (mag + ((PROD_W'(1) << FRAC) >> 1)) >> FRAC;
        r.value = clamp((a < 0) != (b < 0), mag, ov);
      end
      OP_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          num = abs64(a) << FRAC;
          den = abs64(b);
          mag = (2 * num + den) / (2 * den);
          r.value = clamp((a < 0) != (b < 0), mag, ov);
        end
      end
      OP_MIN: r.value = (a < b) ? a_raw : b_raw;
      OP_MAX: r.value = (a > b) ? a_raw : b_raw;
      OP_INC: begin
        s = a + 1;
        r.value = clamp(s < 0, abs64(s), ov);
      end
      OP_DEC: begin
        s = a - 1;
        r.value = clamp(s < 0, abs64(s), ov);
      end
      default: r.value = '0;
    endcase
    r.ov = ov;
    r.lt = a < b;
    r.eq = a == b;
    r.gt = a > b;
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Scoreboard: every response beat is matched against the oldest prediction.
  always @(posedge clk) begin
    alu_result_t exp_r;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $error("response beat with no prediction waiting");
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (rsp.result_value !== exp_r.value) begin
          $error("result_value: expected %h, actual %h", exp_r.value, rsp.result_value);
          error_count++;
        end
        if (rsp.a_less !== exp_r.lt) begin
          $error("a_less: expected %b, actual %b", exp_r.lt, rsp.a_less);
          error_count++;
        end
        if (rsp.a_equal !== exp_r.eq) begin
          $error("a_equal: expected %b, actual %b", exp_r.eq, rsp.a_equal);
          error_count++;
        end
        if (rsp.a_greater !== exp_r.gt) begin
          $error("a_greater: expected %b, actual %b", exp_r.gt, rsp.a_greater);
          error_count++;
        end
        if (rsp.div_zero !== exp_r.dz) begin
          $error("div_zero: expected %b, actual %b", exp_r.dz, rsp.div_zero);
          error_count++;
        end
        if (rsp.overflowed !== exp_r.ov) begin
          $error("overflowed: expected %b, actual %b", exp_r.ov, rsp.overflowed);
          error_count++;
        end
      end
    end
  end

  // Holds valid until the beat is taken, then pushes its prediction.
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] a,
                           input logic [DATA_W-1:0] b, input bit typed,
                           input alu_result_t typed_res);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.req_type  <= op;
    req.operand_a <= a;
    req.operand_b <= b;
    do @(posedge clk); while (!req.ready);
    pending_results.push_back(typed ? typed_res : compute_alu(op, a, b));
  endtask

  function automatic logic [DATA_W-1:0] random_operand();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF - $urandom_range(2);
      1: return 32'h8000_0000 + $urandom_range(2);
      2: return $urandom_range(4) - 2;
      3: return $urandom_range(4095) - 2048;
      4: return $urandom_range(32'h0FFFFF) - 32'h080000;
      default: return $urandom;
    endcase
  endfunction

  stim_row_t directed_rows[$];

  task automatic add_row(input op_t op, input logic [DATA_W-1:0] a,
                         input logic [DATA_W-1:0] b, input bit typed,
                         input logic [DATA_W-1:0] v, input logic [4:0] flags);
    stim_row_t row;
    row.op    = op;
    row.a     = a;
    row.b     = b;
    row.typed = typed;
    row.res   = {v, flags};
    directed_rows.push_back(row);
  endtask

  initial begin
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    int                phase;
    req.valid     = 1'b0;
    req.req_type  = '0;
    req.operand_a = '0;
    req.operand_b = '0;
    // Flags column order: less, equal, greater, div_zero, overflowed.
    add_row(OP_ADD, 32'h7FFF_FFFF, 32'h1, 1, 32'h7FFF_FFFF, 5'b00101);
    add_row(OP_ADD, 32'h8000_0000, 32'h8000_0000, 1, 32'h8000_0000, 5'b01001);
    add_row(OP_SUB, 32'h8000_0000, 32'h1, 1, 32'h8000_0000, 5'b10001);
    add_row(OP_SUB, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, 5'b00101);
    add_row(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 5'b01001);
    add_row(OP_MUL, 32'h8000_0000, 32'h0000_0100, 0, '0, '0);
    add_row(OP_MUL, 32'h0000_0080, 32'h0000_0001, 0, '0, '0);
    add_row(OP_MUL, 32'hFFFF_FF80, 32'h0000_0001, 0, '0, '0);
    add_row(OP_MUL, 32'h0000_0180, 32'hFFFF_FE80, 0, '0, '0);
    add_row(OP_DIV, 32'h1234_5678, 32'h0, 1, 32'h0, 5'b00110);
    add_row(OP_DIV, 32'h0, 32'h0, 1, 32'h0, 5'b01010);
    add_row(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, 5'b10001);
    add_row(OP_DIV, 32'h0000_0001, 32'h0000_0200, 0, '0, '0);
    add_row(OP_DIV, 32'hFFFF_FFFF, 32'h0000_0200, 0, '0, '0);
    add_row(OP_DIV, 32'h0000_0300, 32'hFFFF_F900, 0, '0, '0);
    add_row(OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h8000_0000, 5'b10000);
    add_row(OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 5'b10000);
    add_row(OP_MIN, 32'h55, 32'h55, 1, 32'h55, 5'b01000);
    add_row(OP_INC, 32'h7FFF_FFFF, 32'h0, 1, 32'h7FFF_FFFF, 5'b00101);
    add_row(OP_DEC, 32'h8000_0000, 32'h0, 1, 32'h8000_0000, 5'b10001);
    add_row(OP_INC, 32'hFFFF_FFFF, 32'h5, 0, '0, '0);
    add_row(OP_CMP, 32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h0, 5'b10000);
    add_row(OP_CMP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'h0, 5'b01000);
    add_row(op_t'(4'hF), 32'hFFFF_FFFF, 32'h8000_0000, 1, 32'h0, 5'b00100);
    add_row(op_t'(4'h9), 32'h0000_0001, 32'h0000_0002, 1, 32'h0, 5'b10000);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                directed_rows[i].typed, directed_rows[i].res);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      phase = i / (N_RANDOM / 4);
      send_idle_pct  = (phase == 1) ? 50 : (phase == 3) ? 28 : 0;
      recv_stall_pct = (phase == 2) ? 50 : (phase == 3) ? 28 : 0;
      // About one beat in ten is sent with idling and receive stalls switched off.
      if ($urandom_range(9) == 0) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      op = ($urandom_range(19) == 0) ? OP_W'($urandom_range(15, 9))
                                     : OP_W'($urandom_range(OP_CMP));
      a  = random_operand();
      b  = ($urandom_range(7) == 0) ? a : random_operand();
      send_beat(op, a, b, 0, '0);
    end
    req.valid <= 1'b0;

    recv_stall_pct = 0;
    wait (pending_results.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
+incdir+rtl/core
rtl/core/fpa_pkg.sv
rtl/core/fpa_ifs.sv
rtl/core/fpa_div_stage.sv
rtl/core/fixed_point_alu.sv
bench/tb.sv
